### hdl/vapl_pkg.sv
// Shared types and codes for the virtual address pool.
package vapl_pkg;

    localparam logic [1:0] FUNC_RESOLVE = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP  = 2'd1;
    localparam logic [1:0] FUNC_CLEANUP = 2'd2;

    localparam logic [1:0] ST_EXISTING = 2'd0;
    localparam logic [1:0] ST_NEW      = 2'd1;
    localparam logic [1:0] ST_EVICTED  = 2'd2;
    localparam logic [1:0] ST_NO_RANGE = 2'd3;

    localparam logic CFG_BASE   = 1'b0;
    localparam logic CFG_PREFIX = 1'b1;

    localparam logic [8:0] REMOVED_MAX = 9'd511;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] name_key;
        logic [31:0] query_address;
        logic [63:0] now_ms;
        logic [63:0] age_limit_ms;
    } t_req;

    typedef struct packed {
        logic [31:0] mapped_address;
        logic [63:0] found_key;
        logic        found;
        logic [1:0]  status;
        logic [8:0]  removed_count;
        logic        table_empty;
    } t_rsp;

    typedef struct packed {
        logic start;
        logic kscan;
        logic commit_hit;
        logic fscan;
        logic evict;
        logic look;
        logic lres;
        logic clean;
        logic clean_done;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic ks_done;
        logic hit;
        logic fs_free;
        logic fs_last;
        logic cl_done;
        logic out_busy;
    } t_stat;

endpackage

### hdl/vapl_ctrl.sv
// Request sequencer for the virtual address pool.
module vapl_ctrl import vapl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    output logic       o_in_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_KSCAN = 7'b0000010,
        S_FSCAN = 7'b0000100,
        S_LOOK  = 7'b0001000,
        S_LRES  = 7'b0010000,
        S_CLEAN = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    unique case (i_func)
                        FUNC_RESOLVE: n_state = S_KSCAN;
                        FUNC_LOOKUP:  n_state = S_LOOK;
                        FUNC_CLEANUP: n_state = S_CLEAN;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            S_KSCAN: begin
                o_cmd.kscan = 1'b1;
                if (i_stat.ks_done) begin
                    if (i_stat.hit) begin
                        o_cmd.commit_hit = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FSCAN;
                    end
                end
            end
            S_FSCAN: begin
                o_cmd.fscan = 1'b1;
                if (i_stat.fs_free) begin
                    n_state = S_DONE;
                end else if (i_stat.fs_last) begin
                    o_cmd.evict = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state = S_LRES;
            end
            S_LRES: begin
                o_cmd.lres = 1'b1;
                n_state = S_DONE;
            end
            S_CLEAN: begin
                o_cmd.clean = 1'b1;
                if (i_stat.cl_done) begin
                    o_cmd.clean_done = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/vapl_dp.sv
// Pool datapath: entry memories, valid bits, scan counters and result register.
module vapl_dp import vapl_pkg::*; #(
    parameter int OB = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  t_req        i_req,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_rsp
);

    localparam int DEPTH = 1 << OB;
    localparam logic [4:0] MIN_PFX = 5'(32 - OB);

    logic [63:0] mem_key  [DEPTH];
    logic [63:0] mem_time [DEPTH];

    logic [31:0]      r_base;
    logic [4:0]       r_pfx;
    logic [DEPTH-1:0] r_vld;
    logic [OB:0]      r_cnt;
    logic [OB-1:0]    r_cur;
    logic             r_ov;
    t_rsp             r_out;
    t_rsp             n_out;

    t_req          r_req;
    t_rsp          r_res;
    logic [OB:0]   r_idx;
    logic          r_pv;
    logic [OB-1:0] r_pidx;
    logic          r_hit;
    logic [OB-1:0] r_hidx;
    logic          r_any;
    logic [OB-1:0] r_vidx;
    logic [63:0]   r_vtime;
    logic [OB-1:0] r_fcnt;
    logic [8:0]    r_rem;
    logic [63:0]   r_rkey;
    logic [63:0]   r_rtime;

    logic [4:0]    pfx;
    logic [5:0]    hb;
    logic [OB:0]   size;
    logic [OB-1:0] omask;
    logic [31:0]   mask32;
    logic [31:0]   base;
    logic          issue;
    logic          rd_en;
    logic [OB-1:0] rd_addr;
    logic [OB-1:0] look_off;
    logic          pv_valid;
    logic          kmatch;
    logic          kolder;
    logic          aged;
    logic          cremove;
    logic [OB-1:0] fs_off;
    logic          fs_free;
    logic          alloc;
    logic          wr_en;
    logic          wr_key;
    logic [OB-1:0] wr_addr;
    logic          look_hit;

    always_comb begin
        pfx    = (r_pfx < MIN_PFX) ? MIN_PFX : r_pfx;
        hb     = 6'd32 - {1'b0, pfx};
        size   = (OB+1)'(1) << hb;
        omask  = OB'(size - (OB+1)'(1));
        mask32 = 32'hFFFF_FFFF << hb;
        base   = r_base & mask32;
    end

    assign issue    = (r_idx < size) && !r_hit;
    assign look_off = r_req.query_address[OB-1:0] & omask;
    assign rd_en    = ((i_cmd.kscan || i_cmd.clean) && issue) || i_cmd.look;
    assign rd_addr  = i_cmd.look ? look_off : r_idx[OB-1:0];

    assign pv_valid = r_vld[r_pidx];
    assign kmatch   = i_cmd.kscan && r_pv && !r_hit && pv_valid && (r_rkey == r_req.name_key);
    assign kolder   = i_cmd.kscan && r_pv && pv_valid && (!r_any || (r_rtime < r_vtime));
    assign aged     = (r_req.now_ms > r_rtime) &&
                      ((r_req.now_ms - r_rtime) > r_req.age_limit_ms);
    assign cremove  = i_cmd.clean && r_pv && pv_valid && aged;

    assign fs_off  = OB'(r_cur + r_fcnt) & omask;
    assign fs_free = (fs_off != '0) && (fs_off != omask) && !r_vld[fs_off];
    assign alloc   = i_cmd.fscan && fs_free;

    assign wr_en   = alloc || i_cmd.commit_hit || (i_cmd.evict && r_any);
    assign wr_key  = !i_cmd.commit_hit;
    assign wr_addr = alloc ? fs_off : (i_cmd.commit_hit ? r_hidx : r_vidx);

    assign look_hit = ((r_req.query_address & mask32) == base) && r_vld[look_off];

    always_comb begin
        o_stat.ks_done  = !r_pv && (r_hit || (r_idx == size));
        o_stat.hit      = r_hit;
        o_stat.fs_free  = fs_free;
        o_stat.fs_last  = (r_fcnt == omask);
        o_stat.cl_done  = !r_pv && (r_idx == size);
        o_stat.out_busy = r_ov && !i_out_ready;
    end

    always_comb begin
        n_out             = r_res;
        n_out.table_empty = (r_cnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (wr_key) begin
                mem_key[wr_addr] <= r_req.name_key;
            end
            mem_time[wr_addr] <= r_req.now_ms;
        end
        if (rd_en) begin
            r_rkey  <= mem_key[rd_addr];
            r_rtime <= mem_time[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_pfx  <= 5'd24;
            r_vld  <= '0;
            r_cnt  <= '0;
            r_cur  <= OB'(1);
            r_ov   <= 1'b0;
            r_pv   <= 1'b0;
            r_hit  <= 1'b0;
            r_any  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BASE) begin
                    r_base <= i_cfg_data;
                end else begin
                    r_pfx <= i_cfg_data[4:0];
                end
                r_vld <= '0;
                r_cnt <= '0;
                r_cur <= OB'(1);
            end else if (alloc) begin
                r_vld[fs_off] <= 1'b1;
                r_cnt <= r_cnt + (OB+1)'(1);
                r_cur <= OB'(fs_off + OB'(1)) & omask;
            end else if (cremove) begin
                r_vld[r_pidx] <= 1'b0;
                r_cnt <= r_cnt - (OB+1)'(1);
            end

            if (i_cmd.start) begin
                r_pv  <= 1'b0;
                r_hit <= 1'b0;
                r_any <= 1'b0;
            end else begin
                if (i_cmd.kscan || i_cmd.clean) begin
                    r_pv <= issue;
                end
                if (kmatch) begin
                    r_hit <= 1'b1;
                end
                if (kolder) begin
                    r_any <= 1'b1;
                end
            end

            if (i_cmd.push) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req  <= i_req;
            r_res  <= '0;
            r_idx  <= '0;
            r_fcnt <= '0;
            r_rem  <= '0;
        end else begin
            if ((i_cmd.kscan || i_cmd.clean) && issue) begin
                r_idx  <= r_idx + (OB+1)'(1);
                r_pidx <= r_idx[OB-1:0];
            end
            if (kmatch) begin
                r_hidx <= r_pidx;
            end
            if (kolder) begin
                r_vidx  <= r_pidx;
                r_vtime <= r_rtime;
            end
            if (i_cmd.fscan && !fs_free) begin
                r_fcnt <= r_fcnt + OB'(1);
            end
            if (cremove && (r_rem != REMOVED_MAX)) begin
                r_rem <= r_rem + 9'd1;
            end
            if (i_cmd.commit_hit) begin
                r_res.mapped_address <= base + 32'(r_hidx);
                r_res.status         <= ST_EXISTING;
            end
            if (alloc) begin
                r_res.mapped_address <= base + 32'(fs_off);
                r_res.status         <= ST_NEW;
            end
            if (i_cmd.evict) begin
                if (r_any) begin
                    r_res.mapped_address <= base + 32'(r_vidx);
                    r_res.status         <= ST_EVICTED;
                end else begin
                    r_res.mapped_address <= base;
                    r_res.status         <= ST_NO_RANGE;
                end
            end
            if (i_cmd.lres) begin
                r_res.found     <= look_hit;
                r_res.found_key <= look_hit ? r_rkey : 64'd0;
            end
            if (i_cmd.clean_done) begin
                r_res.removed_count <= r_rem;
            end
        end
        if (i_cmd.push) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_rsp       = r_out;

    a_cnt_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) == (r_vld == '0))
        else $error("valid count disagrees with valid bits");

    a_alloc_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc && !i_cfg_we |=> r_vld[$past(fs_off)])
        else $error("allocated entry not marked valid");

    a_cursor_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur != '0)
        else $error("allocation cursor on network offset");

endmodule

### hdl/virtual_address_pool_lru.sv
// Top level of the virtual address pool with LRU eviction.
//   channel | direction | handshake                   | payload
//   request | in        | i_in_valid / o_in_ready     | i_req (t_req)
//   result  | out       | o_out_valid / i_out_ready   | o_rsp (t_rsp)
//   config  | in        | i_cfg_we                    | i_cfg_idx, i_cfg_data
// Resolve: key scan over the pool (ends early on a hit), then, on a miss, a free scan over
// up to size offsets, with LRU eviction if none is free; size is 2^(32-prefix), at most
// 2^OFFSET_BITS. Lookup: one entry read, then the result. Cleanup: an age scan over the
// pool. The key and cleanup scans are bound by the single entry memory read port.
// One request at a time; the next is taken while the previous result waits.
// Reset clears valid bits at once; no clearing pass is needed.
module virtual_address_pool_lru import vapl_pkg::*; #(
    parameter int OFFSET_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_rsp,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    vapl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_req.func),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vapl_dp #(.OB(OFFSET_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_rsp       (o_rsp)
    );

endmodule

### dv/virtual_address_pool_lru_tb.sv
// Self-checking testbench for the virtual address pool with LRU eviction.
module virtual_address_pool_lru_tb;
    import vapl_pkg::*;

    localparam int POOL = 256;
    localparam int WD_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_req        i_req;
    logic        o_out_valid;
    logic        i_out_ready;
    t_rsp        o_rsp;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;

    virtual_address_pool_lru DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_req(i_req),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_rsp(o_rsp),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [31:0] pool_base;
    logic [4:0]  pool_prefix;
    logic        slot_used [POOL];
    logic [63:0] slot_key  [POOL];
    logic [63:0] slot_time [POOL];
    logic [7:0]  next_free;

    t_rsp rsp_pending [$];
    int   mismatches = 0;
    int   n_sent;
    int   n_got = 0;
    int   idle_cycles = 0;
    int   rx_hold = 0;
    int   hold_asks = 0;
    int   hold_seen = 0;
    bit   rx_calm;
    bit   tx_calm;
    bit   dir_check;
    t_rsp dir_rsp;

    // key pool kept small so resolves hit existing entries often
    logic [63:0] known_keys [16];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int host_bits_of();
        int p;
        p = pool_prefix;
        if (p < 24) p = 24;
        return 32 - p;
    endfunction

    function automatic void pool_clear();
        for (int i = 0; i < POOL; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_time[i] = '0;
        end
        next_free = 8'd1;
    endfunction

    function automatic t_rsp pool_predict(t_req r);
        t_rsp        o;
        int          hb;
        int          size;
        int          omask;
        int          off;
        int          victim;
        bit          done;
        bit          any;
        logic [31:0] mask;
        logic [31:0] base;
        int          cnt;
        hb = host_bits_of();
        size = 1 << hb;
        omask = size - 1;
        mask = 32'hFFFF_FFFF << hb;
        base = pool_base & mask;
        o = '0;
        done = 1'b0;
        if (r.func == FUNC_RESOLVE) begin
            for (int i = 0; i < size && !done; i++)
                if (slot_used[i] && slot_key[i] == r.name_key) begin
                    slot_time[i] = r.now_ms;
                    o.mapped_address = base + i;
                    o.status = ST_EXISTING;
                    done = 1'b1;
                end
            for (int i = 0; i < size && !done; i++) begin
                off = (next_free + i) & omask;
                if (off != 0 && off != omask && !slot_used[off]) begin
                    slot_used[off] = 1'b1;
                    slot_key[off] = r.name_key;
                    slot_time[off] = r.now_ms;
                    next_free = 8'((off + 1) & omask);
                    o.mapped_address = base + off;
                    o.status = ST_NEW;
                    done = 1'b1;
                end
            end
            if (!done) begin
                any = 1'b0;
                victim = 0;
                for (int i = 0; i < size; i++)
                    if (slot_used[i] && (!any || slot_time[i] < slot_time[victim])) begin
                        victim = i;
                        any = 1'b1;
                    end
                if (!any) begin
                    o.mapped_address = base;
                    o.status = ST_NO_RANGE;
                end else begin
                    slot_key[victim] = r.name_key;
                    slot_time[victim] = r.now_ms;
                    o.mapped_address = base + victim;
                    o.status = ST_EVICTED;
                end
            end
        end else if (r.func == FUNC_LOOKUP) begin
            if ((r.query_address & mask) == base) begin
                off = (r.query_address - base) & omask;
                if (slot_used[off]) begin
                    o.found_key = slot_key[off];
                    o.found = 1'b1;
                end
            end
        end else if (r.func == FUNC_CLEANUP) begin
            cnt = 0;
            for (int i = 0; i < size; i++)
                if (slot_used[i] && r.now_ms > slot_time[i]
                        && r.now_ms - slot_time[i] > r.age_limit_ms) begin
                    slot_used[i] = 1'b0;
                    if (cnt < REMOVED_MAX) cnt++;
                end
            o.removed_count = 9'(cnt);
        end
        o.table_empty = 1'b1;
        for (int i = 0; i < POOL; i++)
            if (slot_used[i]) o.table_empty = 1'b0;
        return o;
    endfunction

    task automatic cfg_write(logic idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_BASE) pool_base = val;
        else pool_prefix = val[4:0];
        pool_clear();
    endtask

    // sends one request; expected is either typed in or taken from the predictor
    task automatic send_req(t_req r, bit use_typed, t_rsp typed);
        t_rsp p;
        @(negedge i_clk);
        while (!tx_calm && $urandom_range(99) < 11) @(negedge i_clk);
        i_req = r;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        p = pool_predict(r);
        if (use_typed && p != typed)
            $display("directed row disagrees with predictor: %h vs %h", typed, p);
        rsp_pending.push_back(use_typed ? typed : p);
        n_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (rsp_pending.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    function automatic t_req mk(logic [1:0] f, logic [63:0] k, logic [31:0] a,
                                logic [63:0] t, logic [63:0] l);
        t_req r;
        r.func = f; r.name_key = k; r.query_address = a;
        r.now_ms = t; r.age_limit_ms = l;
        return r;
    endfunction

    function automatic t_rsp mr(logic [31:0] a, logic [63:0] k, logic f, logic [1:0] s,
                                logic [8:0] n, logic e);
        t_rsp o;
        o.mapped_address = a; o.found_key = k; o.found = f; o.status = s;
        o.removed_count = n; o.table_empty = e;
        return o;
    endfunction

    function automatic logic [63:0] r64();
        return {$urandom, $urandom};
    endfunction

    // result side
    always @(negedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            rx_hold <= 400;
            i_out_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            i_out_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            i_out_ready <= rx_calm ? 1'b1 : ($urandom_range(99) >= 11);
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_got++;
            if (rsp_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_rsp);
            end else begin
                want = rsp_pending.pop_front();
                if (o_rsp !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: addr %h/%h key %h/%h found %b/%b",
                                  " st %0d/%0d rm %0d/%0d e %b/%b"},
                            want.mapped_address, o_rsp.mapped_address,
                            want.found_key, o_rsp.found_key, want.found, o_rsp.found,
                            want.status, o_rsp.status, want.removed_count,
                            o_rsp.removed_count, want.table_empty, o_rsp.table_empty);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("timeout after %0d requests", n_sent);
            $display("*** FAILED ***");
            $finish;
        end
    end

    typedef struct {
        t_req r;
        bit   typed;
        t_rsp o;
    } t_row;

    initial begin
        t_row        rows [$];
        t_req        r;
        logic [63:0] clock_ms;
        int          sel;
        n_sent = 0;
        rx_calm = 1'b0; tx_calm = 1'b0;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_req = '0; i_out_ready = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = CFG_BASE; i_cfg_data = '0;
        pool_base = '0; pool_prefix = 5'd24; pool_clear();
        for (int i = 0; i < 16; i++) known_keys[i] = r64();
        known_keys[0] = '0;
        known_keys[1] = '1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: defaults after reset, base 0 prefix 24
        rows.push_back('{mk(FUNC_LOOKUP, '0, 32'd1, '0, '0), 1, mr(0, 0, 0, 0, 0, 1)});
        rows.push_back('{mk(FUNC_RESOLVE, '1, '0, 64'd5, '0), 1, mr(1, 0, 0, ST_NEW, 0, 0)});
        rows.push_back('{mk(FUNC_RESOLVE, '0, '0, '1, '0), 1, mr(2, 0, 0, ST_NEW, 0, 0)});
        rows.push_back('{mk(FUNC_RESOLVE, '1, '0, 64'd7, '0), 1,
                         mr(1, 0, 0, ST_EXISTING, 0, 0)});
        rows.push_back('{mk(FUNC_LOOKUP, '0, 32'd1, '0, '0), 1, mr(0, '1, 1, 0, 0, 0)});
        rows.push_back('{mk(FUNC_LOOKUP, '0, 32'h0100_0001, '0, '0), 1,
                         mr(0, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(2'd3, '1, '1, '1, '1), 1, mr(0, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(FUNC_CLEANUP, '0, '0, 64'd7, '0), 1, mr(0, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(FUNC_CLEANUP, '0, '0, '1, 64'd1), 1, mr(0, 0, 0, 0, 1, 0)});
        rows.push_back('{mk(FUNC_CLEANUP, '0, '0, '0, '0), 1, mr(0, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(FUNC_CLEANUP, '0, '0, '1, '1), 1, mr(0, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(FUNC_LOOKUP, '0, 32'd255, '0, '0), 0, '0});
        foreach (rows[i]) send_req(rows[i].r, rows[i].typed, rows[i].o);
        wait_drain();

        // prefix 31: no usable offset; base with all bits set
        cfg_write(CFG_PREFIX, 32'd31);
        cfg_write(CFG_BASE, 32'hFFFF_FFFF);
        send_req(mk(FUNC_RESOLVE, 64'd9, '0, '0, '0), 1,
                 mr(32'hFFFF_FFFE, 0, 0, ST_NO_RANGE, 0, 1));
        send_req(mk(FUNC_LOOKUP, '0, '1, '0, '0), 0, '0);
        wait_drain();

        // prefix 30: two usable offsets, evictions with ties
        cfg_write(CFG_PREFIX, 32'd30);
        for (int i = 0; i < 6; i++)
            send_req(mk(FUNC_RESOLVE, known_keys[i + 2], '1, 64'd100, '0), 0, '0);
        send_req(mk(FUNC_LOOKUP, '0, 32'hFFFF_FFFD, '0, '0), 0, '0);
        wait_drain();

        // random phases over several settings; prefixes clamp to at least 24, so pools stay at most 256 entries
        clock_ms = 64'd1000;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: cfg_write(CFG_PREFIX, 32'd29);
                1: cfg_write(CFG_PREFIX, 32'd0);
                2: cfg_write(CFG_PREFIX, 32'd28);
                default: cfg_write(CFG_PREFIX, $urandom_range(24, 31));
            endcase
            cfg_write(CFG_BASE, $urandom);
            tx_calm = (ph == 2);
            rx_calm = (ph == 3);
            for (int n = 0; n < 92; n++) begin
                if (ph == 4 && n == 10) hold_asks++;
                if (ph == 5 && n == 40) wait_drain();
                sel = $urandom_range(99);
                if ($urandom_range(9) == 0) clock_ms = r64();
                else clock_ms = clock_ms + $urandom_range(50);
                r = mk(FUNC_RESOLVE, known_keys[$urandom_range(15)], $urandom,
                       clock_ms, $urandom_range(200));
                if (sel < 8) r.name_key = r64();
                if (sel >= 55 && sel < 80) begin
                    r.func = FUNC_LOOKUP;
                    r.query_address = (pool_base & (32'hFFFF_FFFF << host_bits_of()))
                                      + $urandom_range(255);
                    if ($urandom_range(4) == 0) r.query_address = $urandom;
                end else if (sel >= 80 && sel < 95) begin
                    r.func = FUNC_CLEANUP;
                    if ($urandom_range(3) == 0) r.age_limit_ms = r64();
                end else if (sel >= 95) begin
                    r.func = 2'd3;
                end
                send_req(r, 0, '0);
            end
            wait_drain();
        end

        $display("Covered %0d requests and %0d results across directed rows,", n_sent, n_got);
        $display("prefixes 24..31, evictions, cleanups and receiver hold-offs.");
        if (mismatches == 0 && rsp_pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
